/* hdl/aspe_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the Annex B parameter-set extractor.
// No dependencies; every other file of the block refers to this package.
package aspe_pkg;

	localparam int unsigned NRES       = 4;                 // results one byte can release
	localparam int unsigned RES_IDX_W  = $clog2(NRES);
	localparam int unsigned RES_CNT_W  = $clog2(NRES + 1);
	localparam int unsigned BQ_DEPTH   = 4;                 // bundle queue depth
	localparam int unsigned BQ_PTR_W   = $clog2(BQ_DEPTH);
	localparam int unsigned BQ_CNT_W   = $clog2(BQ_DEPTH + 1);
	localparam int unsigned NAL_TYPE_W = 5;

	localparam logic [7:0] EMU_BYTE   = 8'h03;
	localparam logic [7:0] START_BYTE = 8'h01;
	localparam logic [7:0] ZERO_BYTE  = 8'h00;

	localparam logic [NAL_TYPE_W-1:0] FIRST_TYPE_RST  = 5'd7;
	localparam logic [NAL_TYPE_W-1:0] SECOND_TYPE_RST = 5'd8;

	// configuration register indexes
	localparam logic REG_FIRST_TYPE  = 1'b0;
	localparam logic REG_SECOND_TYPE = 1'b1;

	typedef struct packed {
		logic [7:0] data;
		logic       kind;
		logic       last;
		logic       both;
	} res_t;

	// all results released by one input byte, oldest in entry 0
	typedef struct packed {
		res_t [NRES-1:0]      ent;
		logic [RES_CNT_W-1:0] cnt;
	} bundle_t;

endpackage

/* hdl/annexb_sps_pps_extractor_core.sv */
`timescale 1ns / 1ps
// Annex B SPS/PPS extractor, top level. Uses aspe_pkg, aspe_front, aspe_bq, aspe_back.
// Throughput: one stream byte per cycle while the bundle queue has room; one result per cycle
// at the output while the consumer pops, so a byte that releases n results takes n output transactions.
// Path: a released result is registered in the bundle queue and then in the output register;
// the last captured byte waits for the next byte (or the buffer end).
// Reset (arst_n low, asynchronous): parser searching, queues empty, types back to 7 and 8.
module annexb_sps_pps_extractor_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// stream input, queue style
	input  logic                           push,
	output logic                           full,
	input  logic [7:0]                     in_byte,
	input  logic                           in_first,
	input  logic                           in_end,
	// result output, queue style
	output logic                           empty,
	input  logic                           pop,
	output logic [7:0]                     out_byte,
	output logic                           out_kind,
	output logic                           out_last,
	output logic                           both_found,
	// configuration writes
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [aspe_pkg::NAL_TYPE_W-1:0] cfg_data
);

	aspe_pkg::bundle_t bd;
	aspe_pkg::bundle_t bq_head;
	logic              bd_push;
	logic              bq_full;
	logic              bq_empty;
	logic              bq_pop;
	logic              take;

	// Hold the input off only while the bundle queue has no room; an input
	// transaction is taken even when it releases no result.
	assign full = bq_full;
	assign take = push && !bq_full;

	// Front end: classify each byte, drop emulation bytes, build the bundle of
	// results this byte releases (none to four).
	aspe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.in_byte   (in_byte),
		.in_first  (in_first),
		.in_end    (in_end),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.bd_push   (bd_push),
		.bd        (bd)
	);

	// Decouple the two sides: empty bundles never enter the queue.
	aspe_bq u_bq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (bd_push),
		.push_data (bd),
		.pop       (bq_pop),
		.head      (bq_head),
		.full      (bq_full),
		.empty     (bq_empty)
	);

	// Back end: advance through the head bundle, one result per output transaction.
	aspe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (bq_head),
		.bq_empty   (bq_empty),
		.bq_pop     (bq_pop),
		.pop        (pop),
		.empty      (empty),
		.out_byte   (out_byte),
		.out_kind   (out_kind),
		.out_last   (out_last),
		.both_found (both_found)
	);

endmodule

/* hdl/aspe_front.sv */
`timescale 1ns / 1ps
// Front end: start code search, NAL type match, emulation byte removal.
// Turns each accepted byte into a bundle of results. Depends on aspe_pkg.
module aspe_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           take,
	input  logic [7:0]                     in_byte,
	input  logic                           in_first,
	input  logic                           in_end,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [aspe_pkg::NAL_TYPE_W-1:0] cfg_data,
	output logic                           bd_push,
	output aspe_pkg::bundle_t              bd
);

	typedef enum logic [3:0] {
		PH_SEEK    = 4'b0001,
		PH_HEADER  = 4'b0010,
		PH_CAPTURE = 4'b0100,
		PH_DONE    = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_FIRST  = 2'd1,
		KIND_SECOND = 2'd2,
		KIND_BOTH   = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0] zr;
		logic [1:0] hc;
		phase_t     ph;
		kind_t      kd;
		logic       ff;
		logic       sf;
		logic [1:0] emu;
		logic [7:0] pb;
		logic       pv;
	} fst_t;

	typedef struct packed {
		fst_t              st;
		aspe_pkg::bundle_t bd;
	} work_t;

	fst_t                            st_q;
	work_t                           w;
	kind_t                           hdr_kind;
	logic [aspe_pkg::NAL_TYPE_W-1:0] first_type_q;
	logic [aspe_pkg::NAL_TYPE_W-1:0] second_type_q;
	logic [aspe_pkg::NAL_TYPE_W-1:0] hdr_type;

	function automatic work_t put_res(work_t wi, logic [7:0] b, logic last);
		work_t r;
		r = wi;
		r.bd.ent[wi.bd.cnt[aspe_pkg::RES_IDX_W-1:0]].data = b;
		r.bd.ent[wi.bd.cnt[aspe_pkg::RES_IDX_W-1:0]].kind = (wi.st.kd == KIND_SECOND);
		r.bd.ent[wi.bd.cnt[aspe_pkg::RES_IDX_W-1:0]].last = last;
		r.bd.ent[wi.bd.cnt[aspe_pkg::RES_IDX_W-1:0]].both = wi.st.ff & wi.st.sf;
		r.bd.cnt = wi.bd.cnt + aspe_pkg::RES_CNT_W'(1);
		return r;
	endfunction

	// drop 03 after two zeros, otherwise release the held-back byte
	function automatic work_t filter_byte(work_t wi, logic [7:0] b);
		work_t r;
		r = wi;
		if (wi.st.emu == 2'd2 && b == aspe_pkg::EMU_BYTE) begin
			r.st.emu = 2'd0;
		end else begin
			if (b == aspe_pkg::ZERO_BYTE)
				r.st.emu = (wi.st.emu != 2'd2) ? wi.st.emu + 2'd1 : 2'd2;
			else
				r.st.emu = 2'd0;
			if (wi.st.pv)
				r = put_res(r, wi.st.pb, 1'b0);
			r.st.pb = b;
			r.st.pv = 1'b1;
		end
		return r;
	endfunction

	// held bytes are always zeros
	function automatic work_t flush_held(work_t wi);
		work_t r;
		r = wi;
		if (wi.st.hc != 2'd0)
			r = filter_byte(r, aspe_pkg::ZERO_BYTE);
		if (wi.st.hc == 2'd2)
			r = filter_byte(r, aspe_pkg::ZERO_BYTE);
		r.st.hc = 2'd0;
		return r;
	endfunction

	function automatic work_t close_unit(work_t wi);
		work_t r;
		r = wi;
		if (wi.st.kd == KIND_FIRST || wi.st.kd == KIND_BOTH)
			r.st.ff = 1'b1;
		if (wi.st.kd == KIND_SECOND || wi.st.kd == KIND_BOTH)
			r.st.sf = 1'b1;
		if (wi.st.pv)
			r = put_res(r, wi.st.pb, 1'b1);
		r.st.pv  = 1'b0;
		r.st.hc  = 2'd0;
		r.st.kd  = KIND_NONE;
		r.st.emu = 2'd0;
		r.st.ph  = (r.st.ff && r.st.sf) ? PH_DONE : PH_SEEK;
		return r;
	endfunction

	assign hdr_type = in_byte[aspe_pkg::NAL_TYPE_W-1:0];

	always_comb begin
		hdr_kind = KIND_NONE;
		if (hdr_type == first_type_q && !st_q.ff)
			hdr_kind = (hdr_type == second_type_q && !st_q.sf) ? KIND_BOTH : KIND_FIRST;
		else if (hdr_type == second_type_q && !st_q.sf)
			hdr_kind = KIND_SECOND;
	end

	always_comb begin
		w.st = st_q;
		w.bd = '0;

		// a new buffer closes an open capture, then resets the parser
		if (in_first) begin
			if (w.st.ph == PH_CAPTURE)
				w = close_unit(flush_held(w));
			w.st.ff  = 1'b0;
			w.st.sf  = 1'b0;
			w.st.ph  = PH_SEEK;
			w.st.zr  = 2'd0;
			w.st.hc  = 2'd0;
			w.st.kd  = KIND_NONE;
			w.st.pv  = 1'b0;
			w.st.emu = 2'd0;
		end

		case (w.st.ph)
			PH_SEEK: begin
				if (in_byte == aspe_pkg::START_BYTE && w.st.zr >= 2'd2) begin
					w.st.ph = PH_HEADER;
					w.st.zr = 2'd0;
				end else if (in_byte == aspe_pkg::ZERO_BYTE) begin
					w.st.zr = (w.st.zr != 2'd3) ? w.st.zr + 2'd1 : 2'd3;
				end else begin
					w.st.zr = 2'd0;
				end
			end
			PH_HEADER: begin
				w.st.zr = 2'd0;
				if (hdr_kind != KIND_NONE) begin
					w.st.kd  = hdr_kind;
					w.st.emu = 2'd0;
					w.st.pv  = 1'b0;
					w.st.hc  = 2'd0;
					w        = filter_byte(w, in_byte);
					w.st.ph  = PH_CAPTURE;
				end else begin
					w.st.ph = PH_SEEK;
				end
			end
			PH_CAPTURE: begin
				if (in_byte == aspe_pkg::ZERO_BYTE) begin
					if (w.st.hc != 2'd2) begin
						w.st.hc = w.st.hc + 2'd1;
					end else begin
						w       = close_unit(w);
						w.st.zr = 2'd3;
					end
				end else if (in_byte == aspe_pkg::START_BYTE && w.st.hc == 2'd2) begin
					w       = close_unit(w);
					w.st.zr = 2'd0;
					if (w.st.ph == PH_SEEK)
						w.st.ph = PH_HEADER;
				end else begin
					w = filter_byte(flush_held(w), in_byte);
				end
			end
			default: begin
			end
		endcase

		// buffer end keeps held zeros in the unit and closes it
		if (in_end) begin
			if (w.st.ph == PH_CAPTURE)
				w = close_unit(flush_held(w));
			if (w.st.ph != PH_DONE)
				w.st.ph = PH_SEEK;
			w.st.zr = 2'd0;
		end
	end

	assign bd      = w.bd;
	assign bd_push = take && (w.bd.cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= '{zr: 2'd0, hc: 2'd0, ph: PH_SEEK, kd: KIND_NONE, ff: 1'b0,
			             sf: 1'b0, emu: 2'd0, pb: 8'd0, pv: 1'b0};
		end else if (take) begin
			st_q <= w.st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_type_q  <= aspe_pkg::FIRST_TYPE_RST;
			second_type_q <= aspe_pkg::SECOND_TYPE_RST;
		end else if (cfg_we) begin
			if (cfg_index == aspe_pkg::REG_FIRST_TYPE)
				first_type_q <= cfg_data;
			if (cfg_index == aspe_pkg::REG_SECOND_TYPE)
				second_type_q <= cfg_data;
		end
	end

endmodule

/* hdl/aspe_bq.sv */
`timescale 1ns / 1ps
// Bundle queue between front end and back end.
// Small register FIFO of result bundles. Depends on aspe_pkg.
module aspe_bq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  aspe_pkg::bundle_t push_data,
	input  logic              pop,
	output aspe_pkg::bundle_t head,
	output logic              full,
	output logic              empty
);

	aspe_pkg::bundle_t                 mem_q [aspe_pkg::BQ_DEPTH];
	logic [aspe_pkg::BQ_PTR_W-1:0] wr_ptr_q;
	logic [aspe_pkg::BQ_PTR_W-1:0] rd_ptr_q;
	logic [aspe_pkg::BQ_CNT_W-1:0] count_q;
	logic                          do_push;
	logic                          do_pop;

	assign full    = (count_q == aspe_pkg::BQ_CNT_W'(aspe_pkg::BQ_DEPTH));
	assign empty   = (count_q == '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == aspe_pkg::BQ_PTR_W'(aspe_pkg::BQ_DEPTH - 1)) ?
				            '0 : wr_ptr_q + aspe_pkg::BQ_PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == aspe_pkg::BQ_PTR_W'(aspe_pkg::BQ_DEPTH - 1)) ?
				            '0 : rd_ptr_q + aspe_pkg::BQ_PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + aspe_pkg::BQ_CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - aspe_pkg::BQ_CNT_W'(1);
		end
	end

endmodule

/* hdl/aspe_back.sv */
`timescale 1ns / 1ps
// Back end: walks the head bundle one result per cycle into the output register, while the output is empty or popped.
// Depends on aspe_pkg.
module aspe_back (
	input  logic              clk,
	input  logic              arst_n,
	input  aspe_pkg::bundle_t head,
	input  logic              bq_empty,
	output logic              bq_pop,
	input  logic              pop,
	output logic              empty,
	output logic [7:0]        out_byte,
	output logic              out_kind,
	output logic              out_last,
	output logic              both_found
);

	logic [aspe_pkg::RES_IDX_W-1:0] idx_q;
	logic                           out_valid_q;
	aspe_pkg::res_t                 out_q;
	logic                           load;
	logic                           at_last;

	assign load    = !bq_empty && (!out_valid_q || pop);
	assign at_last = (aspe_pkg::RES_CNT_W'(idx_q) + aspe_pkg::RES_CNT_W'(1)) == head.cnt;
	assign bq_pop  = load && at_last;

	always_ff @(posedge clk) begin
		if (load)
			out_q <= head.ent[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= at_last ? '0 : idx_q + aspe_pkg::RES_IDX_W'(1);
			if (load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	assign empty      = !out_valid_q;
	assign out_byte   = out_q.data;
	assign out_kind   = out_q.kind;
	assign out_last   = out_q.last;
	assign both_found = out_q.both;

endmodule
